@@ rtl/sobel_edge_magnitude_rgb_unit_macros.svh @@
// ----------------------------------------------------------------------------
// sobel edge magnitude macros
// assertion helpers shared by the rtl of the sobel edge magnitude unit
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_UNIT_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_UNIT_MACROS_SVH

// same-cycle implication
`define SEMR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sobel unit: same-cycle check failed");

// next-cycle implication
`define SEMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sobel unit: next-cycle check failed");

`endif

@@ rtl/sobel_pkg.sv @@
// ----------------------------------------------------------------------------
// sobel package
// types and constants of the sobel edge magnitude unit
// ----------------------------------------------------------------------------
package sobel_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int POS_W     = 10;
	localparam int PIX_W     = 24;
	localparam int SUM_W     = 21;

	localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;
	localparam logic [SUM_W-1:0] SAT_LIMIT = 21'd65280;
	localparam logic [7:0]       SAT_VALUE = 8'd255;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_GRAD,
		ST_SQX,
		ST_SQY,
		ST_ROOT,
		ST_FIN,
		ST_EMIT_INT,
		ST_EMIT_BRD
	} state_t;

endpackage

@@ rtl/sobel_edge_magnitude_rgb_unit.sv @@
// ----------------------------------------------------------------------------
// sobel edge magnitude rgb unit
// 3x3 sobel gradient magnitude per color channel over a raster rgb stream
// ----------------------------------------------------------------------------
// usage
//   s_* carries one rgb pixel per transfer in raster order; m_* carries results
//   with row, column, pixel, border flag (tuser) and last-of-run flag (tlast).
//   cfg_we/cfg_index/cfg_data set frame width and height; a write to either
//   size register restarts the frame at row 0, column 0.
// timing
//   a pixel with no result passes the shift state only; a border-only pixel
//   adds an emit state. an interior result needs per channel a gradient step,
//   an x and a y step on the shared squaring multiplier, then the digit-by-digit
//   square root and a rounding step; saturated channels skip the root. an item
//   that closes an interior window thus takes longer the more channels need
//   the root iterations of the one shared unit.
//   the interior result of (r-1,c-1) leaves first, then the pixel itself if
//   it lies on the border.
// reset and stall
//   reset clears position, state and output valid; sizes return to 1024.
//   the output register holds a result while m_tready is low; the next pixel
//   is still taken once the sequencer is back idle.
// ----------------------------------------------------------------------------
`include "sobel_edge_magnitude_rgb_unit_macros.svh"

module sobel_edge_magnitude_rgb_unit #(
	parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sobel_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sobel_pkg::CFG_W-1:0]    cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [23:0]                    s_tdata,   // pixel_rgb
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [47:0]                    m_tdata,   // out_row, out_col, out_rgb, zero pad
	output logic                           m_tuser,   // is_border
	output logic                           m_tlast    // last_of_run
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = CW + 1;
	localparam int HW = RW + 1;
	localparam int XW = (WW > sobel_pkg::CFG_W) ? WW : sobel_pkg::CFG_W;
	localparam int YW = (HW > sobel_pkg::CFG_W) ? HW : sobel_pkg::CFG_W;
	localparam int PW = sobel_pkg::PIX_W;

	sobel_pkg::state_t state_q, state_d;

	logic [sobel_pkg::CFG_W-1:0] width_raw_q, height_raw_q;
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [XW-1:0] width_ext;
	logic [YW-1:0] height_ext;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [WW-1:0] col_inc;
	logic [HW-1:0] row_inc;

	logic [CW-1:0] c_q;
	logic [RW-1:0] r_q;
	logic [PW-1:0] pix_q;
	logic          interior_q, border_q;

	logic [2*PW-1:0] line_mem [MAX_WIDTH];
	logic [2*PW-1:0] rd_q;
	logic [PW-1:0]   win_q [9];

	logic [1:0]  ch_q;
	logic [2:0]  it_q;
	logic [7:0]  pb [9];
	logic [11:0] gx, gy;
	logic [9:0]  gx_abs_q, gy_abs_q;
	logic [9:0]  mul_in;
	logic [19:0] prod;
	logic [sobel_pkg::SUM_W-1:0] sq_q, s_sum;
	logic        sat;

	logic [8:0]  rem_q;
	logic [7:0]  root_q;
	logic [1:0]  pair;
	logic [10:0] rem_try, trial;
	logic        ge;
	logic [7:0]  fin_byte;
	logic [PW-1:0] res_q;

	logic accept, out_load;
	logic [sobel_pkg::POS_W-1:0] out_row_q, out_col_q;
	logic [PW-1:0] out_rgb_q;
	logic          out_border_q, out_last_q, m_tvalid_q;

	// effective frame size
	always_comb begin
		width_ext  = XW'(width_raw_q);
		height_ext = YW'(height_raw_q);
		if (width_raw_q == '0) begin
			w_eff = WW'(1);
		end else if (width_ext > XW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_ext);
		end
		if (height_raw_q == '0) begin
			h_eff = HW'(1);
		end else if (height_ext > YW'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_ext);
		end
	end

	assign col_inc = {1'b0, col_q} + WW'(1);
	assign row_inc = {1'b0, row_q} + HW'(1);

	// gradient of the selected channel
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			pb[k] = win_q[k][{ch_q, 3'b000} +: 8];
		end
		gx = (12'(pb[2]) + {3'b000, pb[5], 1'b0} + 12'(pb[8]))
		   - (12'(pb[0]) + {3'b000, pb[3], 1'b0} + 12'(pb[6]));
		gy = (12'(pb[6]) + {3'b000, pb[7], 1'b0} + 12'(pb[8]))
		   - (12'(pb[0]) + {3'b000, pb[1], 1'b0} + 12'(pb[2]));
	end

	// shared squaring multiplier
	assign mul_in = (state_q == sobel_pkg::ST_SQX) ? gx_abs_q : gy_abs_q;
	assign prod   = mul_in * mul_in;
	assign s_sum  = sq_q + sobel_pkg::SUM_W'(prod);
	assign sat    = s_sum > sobel_pkg::SAT_LIMIT;

	// one root digit per cycle
	assign pair     = sq_q[{3'd7 - it_q, 1'b0} +: 2];
	assign rem_try  = {rem_q, pair};
	assign trial    = {1'b0, root_q, 2'b01};
	assign ge       = rem_try >= trial;
	assign fin_byte = root_q + 8'(rem_q > {1'b0, root_q});

	assign accept   = (state_q == sobel_pkg::ST_IDLE) && s_tvalid;
	assign s_tready = (state_q == sobel_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sobel_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		unique case (state_q)
			sobel_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = sobel_pkg::ST_SHIFT;
			end
			sobel_pkg::ST_SHIFT: begin
				priority if (interior_q) state_d = sobel_pkg::ST_GRAD;
				else if (border_q)       state_d = sobel_pkg::ST_EMIT_BRD;
				else                     state_d = sobel_pkg::ST_IDLE;
			end
			sobel_pkg::ST_GRAD: state_d = sobel_pkg::ST_SQX;
			sobel_pkg::ST_SQX:  state_d = sobel_pkg::ST_SQY;
			sobel_pkg::ST_SQY: begin
				priority if (!sat)     state_d = sobel_pkg::ST_ROOT;
				else if (ch_q == 2'd2) state_d = sobel_pkg::ST_EMIT_INT;
				else                   state_d = sobel_pkg::ST_GRAD;
			end
			sobel_pkg::ST_ROOT: begin
				if (it_q == 3'd7) state_d = sobel_pkg::ST_FIN;
			end
			sobel_pkg::ST_FIN: begin
				state_d = (ch_q == 2'd2) ? sobel_pkg::ST_EMIT_INT : sobel_pkg::ST_GRAD;
			end
			sobel_pkg::ST_EMIT_INT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = border_q ? sobel_pkg::ST_EMIT_BRD : sobel_pkg::ST_IDLE;
				end
			end
			sobel_pkg::ST_EMIT_BRD: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = sobel_pkg::ST_IDLE;
				end
			end
			default: state_d = sobel_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_raw_q  <= sobel_pkg::DIM_RESET;
			height_raw_q <= sobel_pkg::DIM_RESET;
			col_q        <= '0;
			row_q        <= '0;
			ch_q         <= '0;
			it_q         <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sobel_pkg::REG_FRAME_WIDTH: begin
						width_raw_q <= cfg_data;
						col_q       <= '0;
						row_q       <= '0;
					end
					sobel_pkg::REG_FRAME_HEIGHT: begin
						height_raw_q <= cfg_data;
						col_q        <= '0;
						row_q        <= '0;
					end
					default: ;
				endcase
			end else if (accept) begin
				if (col_inc >= w_eff) begin
					col_q <= '0;
					row_q <= (row_inc >= h_eff) ? '0 : RW'(row_inc);
				end else begin
					col_q <= CW'(col_inc);
				end
			end
			if (state_q == sobel_pkg::ST_SHIFT) begin
				ch_q <= '0;
			end else if ((state_q == sobel_pkg::ST_FIN) ||
					((state_q == sobel_pkg::ST_SQY) && sat)) begin
				ch_q <= ch_q + 2'd1;
			end
			if (state_q == sobel_pkg::ST_ROOT) begin
				it_q <= it_q + 3'd1;
			end else begin
				it_q <= '0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// row stores, read at accept and written back in the following shift state
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= line_mem[col_q];
		end
		if (state_q == sobel_pkg::ST_SHIFT) begin
			line_mem[c_q] <= {rd_q[PW-1:0], pix_q};
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q      <= s_tdata;
			c_q        <= col_q;
			r_q        <= row_q;
			interior_q <= (row_q >= RW'(2)) && (col_q >= CW'(2));
			border_q   <= (row_q == '0) || (col_q == '0) ||
				({1'b0, row_q} == h_eff - HW'(1)) || ({1'b0, col_q} == w_eff - WW'(1));
		end
		unique case (state_q)
			sobel_pkg::ST_SHIFT: begin
				for (int k = 0; k < 3; k++) begin
					win_q[3*k]   <= win_q[3*k+1];
					win_q[3*k+1] <= win_q[3*k+2];
				end
				win_q[2] <= rd_q[2*PW-1:PW];
				win_q[5] <= rd_q[PW-1:0];
				win_q[8] <= pix_q;
			end
			sobel_pkg::ST_GRAD: begin
				gx_abs_q <= 10'(gx[11] ? (~gx + 12'd1) : gx);
				gy_abs_q <= 10'(gy[11] ? (~gy + 12'd1) : gy);
			end
			sobel_pkg::ST_SQX: begin
				sq_q <= sobel_pkg::SUM_W'(prod);
			end
			sobel_pkg::ST_SQY: begin
				sq_q   <= s_sum;
				rem_q  <= '0;
				root_q <= '0;
				if (sat) res_q[{ch_q, 3'b000} +: 8] <= sobel_pkg::SAT_VALUE;
			end
			sobel_pkg::ST_ROOT: begin
				rem_q  <= 9'(ge ? (rem_try - trial) : rem_try);
				root_q <= {root_q[6:0], ge};
			end
			sobel_pkg::ST_FIN: begin
				res_q[{ch_q, 3'b000} +: 8] <= fin_byte;
			end
			default: ;
		endcase
		if (out_load) begin
			if (state_q == sobel_pkg::ST_EMIT_INT) begin
				out_row_q    <= sobel_pkg::POS_W'(r_q - RW'(1));
				out_col_q    <= sobel_pkg::POS_W'(c_q - CW'(1));
				out_rgb_q    <= res_q;
				out_border_q <= 1'b0;
				out_last_q   <= !border_q;
			end else begin
				out_row_q    <= sobel_pkg::POS_W'(r_q);
				out_col_q    <= sobel_pkg::POS_W'(c_q);
				out_rgb_q    <= pix_q;
				out_border_q <= 1'b1;
				out_last_q   <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, out_rgb_q, out_col_q, out_row_q};
	assign m_tuser  = out_border_q;
	assign m_tlast  = out_last_q;

	`SEMR_ASSERT_NEXT(a_busy_after_transfer, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`SEMR_ASSERT_NOW(a_col_in_frame, clk, arst_n, 1'b1, {1'b0, col_q} < w_eff)
	`SEMR_ASSERT_NOW(a_root_not_saturated, clk, arst_n,
		state_q == sobel_pkg::ST_ROOT, sq_q <= sobel_pkg::SAT_LIMIT)
	`SEMR_ASSERT_NOW(a_root_remainder_bound, clk, arst_n,
		state_q == sobel_pkg::ST_FIN, {1'b0, rem_q} <= {1'b0, root_q, 1'b0})
	`SEMR_ASSERT_NOW(a_load_only_when_free, clk, arst_n,
		out_load, !m_tvalid_q || m_tready)

endmodule
